FILE: rtl/triple_magma_cbc_cipher_top_macros.svh
// ----------------------------------------------------------------------------
// Triple Magma CBC cipher assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TRIPLE_MAGMA_CBC_CIPHER_TOP_MACROS_SVH
`define TRIPLE_MAGMA_CBC_CIPHER_TOP_MACROS_SVH

// Same-cycle implication.
`define TMC_ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tmagma assertion failed");

// Next-cycle implication.
`define TMC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tmagma assertion failed");

`endif

FILE: rtl/tmagma_pkg.sv
// ----------------------------------------------------------------------------
// Triple Magma package
// Widths, codes, S-boxes and the Magma round function.
// ----------------------------------------------------------------------------
package tmagma_pkg;

	localparam int BLOCK_W  = 64;
	localparam int HALF_W   = 32;
	localparam int KEY_WORDS = 24;
	localparam int ROT      = 11;

	typedef logic [BLOCK_W-1:0] block_t;
	typedef logic [HALF_W-1:0]  half_t;
	typedef logic [3:0]         nib_t;

	typedef enum logic {
		CMD_KEY   = 1'b0,
		CMD_BLOCK = 1'b1
	} cmd_t;

	typedef enum logic {
		CFG_INIT_VECTOR  = 1'b0,
		CFG_DECRYPT_MODE = 1'b1
	} cfg_idx_t;

	localparam logic [1:0] KEY_SEL_NONE = 2'd3;
	localparam logic [1:0] LAST_PASS    = 2'd2;

	typedef nib_t sbox_row_t [16];
	typedef sbox_row_t sbox_t [8];

	localparam sbox_t SBOX = '{
		'{4'd12, 4'd4, 4'd6, 4'd2, 4'd10, 4'd5, 4'd11, 4'd9,
		  4'd14, 4'd8, 4'd13, 4'd7, 4'd0, 4'd3, 4'd15, 4'd1},
		'{4'd6, 4'd8, 4'd2, 4'd3, 4'd9, 4'd10, 4'd5, 4'd12,
		  4'd1, 4'd14, 4'd4, 4'd7, 4'd11, 4'd13, 4'd0, 4'd15},
		'{4'd11, 4'd3, 4'd5, 4'd8, 4'd2, 4'd15, 4'd10, 4'd13,
		  4'd14, 4'd1, 4'd7, 4'd4, 4'd12, 4'd9, 4'd6, 4'd0},
		'{4'd12, 4'd8, 4'd2, 4'd1, 4'd13, 4'd4, 4'd15, 4'd6,
		  4'd7, 4'd0, 4'd10, 4'd5, 4'd3, 4'd14, 4'd9, 4'd11},
		'{4'd7, 4'd15, 4'd5, 4'd10, 4'd8, 4'd1, 4'd6, 4'd13,
		  4'd0, 4'd9, 4'd3, 4'd14, 4'd11, 4'd4, 4'd2, 4'd12},
		'{4'd5, 4'd13, 4'd15, 4'd6, 4'd9, 4'd2, 4'd12, 4'd10,
		  4'd11, 4'd7, 4'd8, 4'd1, 4'd4, 4'd3, 4'd14, 4'd0},
		'{4'd8, 4'd14, 4'd2, 4'd5, 4'd6, 4'd9, 4'd1, 4'd12,
		  4'd15, 4'd4, 4'd11, 4'd0, 4'd13, 4'd10, 4'd3, 4'd7},
		'{4'd1, 4'd7, 4'd14, 4'd13, 4'd0, 4'd5, 4'd8, 4'd3,
		  4'd4, 4'd15, 4'd10, 4'd6, 4'd9, 4'd12, 4'd11, 4'd2}
	};

	// Add key, substitute each nibble, rotate left.
	function automatic half_t round_fn(input half_t half, input half_t k);
		half_t a;
		half_t s;
		a = half + k;
		s = '0;
		for (int n = 0; n < 8; n++) begin
			s[4*n +: 4] = SBOX[n][a[4*n +: 4]];
		end
		return {s[HALF_W-ROT-1:0], s[HALF_W-1:HALF_W-ROT]};
	endfunction

endpackage

FILE: rtl/tmagma_in_if.sv
// ----------------------------------------------------------------------------
// Triple Magma input channel
// Valid/ready channel carrying key-load and block requests.
// ----------------------------------------------------------------------------
interface tmagma_in_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [1:0]  key_select;
	logic [2:0]  word_index;
	logic [31:0] key_word;
	logic [63:0] data_block;
	logic        first_block;

	modport source (
		output valid, command, key_select, word_index, key_word, data_block, first_block,
		input  ready
	);
	modport sink (
		input  valid, command, key_select, word_index, key_word, data_block, first_block,
		output ready
	);
endinterface

FILE: rtl/tmagma_out_if.sv
// ----------------------------------------------------------------------------
// Triple Magma output channel
// Valid/ready channel carrying result blocks.
// ----------------------------------------------------------------------------
interface tmagma_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] result_block;

	modport source (output valid, result_block, input ready);
	modport sink (input valid, result_block, output ready);
endinterface

FILE: rtl/tmagma_cfg_if.sv
// ----------------------------------------------------------------------------
// Triple Magma configuration channel
// Valid/ready register write channel with index and data.
// ----------------------------------------------------------------------------
interface tmagma_cfg_if;
	logic        valid;
	logic        ready;
	logic        index;
	logic [63:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/triple_magma_cbc_cipher_top.sv
// ----------------------------------------------------------------------------
// Triple Magma CBC cipher
// Three-key EDE Magma with CBC chaining around one shared round unit.
// ----------------------------------------------------------------------------
// A key-load request writes one word of the key store unless its key select
// is KEY_SEL_NONE. A block request runs 96 rounds through a single Magma
// round unit, one round per cycle unless the last round stalls; the input
// is not ready while a block is in flight. The result sits in an output
// register, and a new request is accepted while it waits, but a block holds
// its last round until the previous result has been taken.
module triple_magma_cbc_cipher_top (
	input  logic clk,
	input  logic arst_n,
	tmagma_in_if.sink    in_ch,
	tmagma_out_if.source out_ch,
	tmagma_cfg_if.sink   cfg_ch
);
	import tmagma_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	state_t      state_q;
	logic [1:0]  pass_q;
	logic [4:0]  round_q;
	half_t       hi_q;
	half_t       lo_q;
	block_t      prev_q;
	block_t      chain_q;
	block_t      iv_q;
	logic        decrypt_q;
	half_t       key_mem_q [KEY_WORDS];
	logic        out_valid_q;
	block_t      result_q;

	logic        in_acc;
	logic        blk_acc;
	logic        last_round;
	logic        finish;
	logic        stall;
	logic        inverse;
	logic [1:0]  key_num;
	logic [2:0]  key_idx;
	half_t       round_key;
	half_t       new_lo;
	block_t      start_blk;
	block_t      end_blk;

	assign in_ch.ready  = (state_q == ST_IDLE);
	assign cfg_ch.ready = 1'b1;
	assign out_ch.valid = out_valid_q;
	assign out_ch.result_block = result_q;

	assign in_acc  = in_ch.valid && in_ch.ready;
	assign blk_acc = in_acc && (in_ch.command == CMD_BLOCK);

	assign last_round = (state_q == ST_RUN) && (pass_q == LAST_PASS) && (round_q == 5'd31);
	assign stall      = last_round && out_valid_q && !out_ch.ready;
	assign finish     = last_round && !stall;

	always_comb begin
		if (!decrypt_q) begin
			inverse = (pass_q == 2'd1);
			key_num = pass_q;
		end else begin
			inverse = (pass_q != 2'd1);
			key_num = LAST_PASS - pass_q;
		end
		if (inverse) begin
			key_idx = (round_q[4:3] == 2'd0) ? round_q[2:0] : ~round_q[2:0];
		end else begin
			key_idx = (round_q[4:3] != 2'd3) ? round_q[2:0] : ~round_q[2:0];
		end
	end

	assign round_key = key_mem_q[{key_num, key_idx}];
	assign new_lo    = round_fn(lo_q, round_key) ^ hi_q;
	assign end_blk   = {new_lo, lo_q};
	assign start_blk = (in_ch.first_block ? iv_q : chain_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iv_q      <= '0;
			decrypt_q <= 1'b0;
		end else if (cfg_ch.valid && cfg_ch.ready) begin
			unique case (cfg_idx_t'(cfg_ch.index))
				CFG_INIT_VECTOR:  iv_q      <= cfg_ch.data;
				CFG_DECRYPT_MODE: decrypt_q <= cfg_ch.data[0];
				default:          ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < KEY_WORDS; i++) begin
				key_mem_q[i] <= '0;
			end
		end else if (in_acc && (in_ch.command == CMD_KEY) &&
				(in_ch.key_select != KEY_SEL_NONE)) begin
			key_mem_q[{in_ch.key_select, in_ch.word_index}] <= in_ch.key_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pass_q      <= '0;
			round_q     <= '0;
			chain_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (blk_acc) begin
						state_q <= ST_RUN;
						pass_q  <= '0;
						round_q <= '0;
						if (decrypt_q) begin
							chain_q <= in_ch.data_block;
						end
					end
				end
				ST_RUN: begin
					if (finish) begin
						state_q     <= ST_IDLE;
						if (!decrypt_q) begin
							chain_q <= end_blk;
						end
					end else if (!stall) begin
						round_q <= round_q + 5'd1;
						if (round_q == 5'd31) begin
							pass_q <= pass_q + 2'd1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (blk_acc) begin
			prev_q <= start_blk;
			if (decrypt_q) begin
				{hi_q, lo_q} <= in_ch.data_block;
			end else begin
				{hi_q, lo_q} <= in_ch.data_block ^ start_blk;
			end
		end else if ((state_q == ST_RUN) && !stall) begin
			if (round_q == 5'd31) begin
				hi_q <= new_lo;
			end else begin
				hi_q <= lo_q;
				lo_q <= new_lo;
			end
		end
		if (finish) begin
			result_q <= decrypt_q ? (end_blk ^ prev_q) : end_blk;
		end
	end

`include "triple_magma_cbc_cipher_top_macros.svh"

	`TMC_ASSERT_NEXT(a_block_starts, blk_acc, (state_q == ST_RUN) && (pass_q == 2'd0) && (round_q == 5'd0))
	`TMC_ASSERT_IMPLY(a_result_from_run, out_valid_q && !$past(out_valid_q), $past(state_q == ST_RUN))
	`TMC_ASSERT_IMPLY(a_pass_range, state_q == ST_RUN, pass_q <= LAST_PASS)
	`TMC_ASSERT_NEXT(a_finish_idle, finish, (state_q == ST_IDLE) && out_valid_q)

endmodule

FILE: verif/triple_magma_cbc_cipher_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triple Magma CBC cipher testbench
// Loads keys and sends blocks in both modes under several IV settings. A
// built-in EDE/CBC predictor computes each result block, and the results are
// checked in order. Input and output idle at random, but for one phase.
// ----------------------------------------------------------------------------
module triple_magma_cbc_cipher_top_tb;
	import tmagma_pkg::*;

	localparam int PHASES       = 11;
	localparam int PHASE_ITEMS  = 85;
	localparam int DRAIN_CYCLES = 120;

	localparam logic [0:7][0:15][3:0] SUBST = {
		4'd12, 4'd4, 4'd6, 4'd2, 4'd10, 4'd5, 4'd11, 4'd9, 4'd14, 4'd8, 4'd13, 4'd7, 4'd0, 4'd3, 4'd15, 4'd1,
		4'd6, 4'd8, 4'd2, 4'd3, 4'd9, 4'd10, 4'd5, 4'd12, 4'd1, 4'd14, 4'd4, 4'd7, 4'd11, 4'd13, 4'd0, 4'd15,
		4'd11, 4'd3, 4'd5, 4'd8, 4'd2, 4'd15, 4'd10, 4'd13, 4'd14, 4'd1, 4'd7, 4'd4, 4'd12, 4'd9, 4'd6, 4'd0,
		4'd12, 4'd8, 4'd2, 4'd1, 4'd13, 4'd4, 4'd15, 4'd6, 4'd7, 4'd0, 4'd10, 4'd5, 4'd3, 4'd14, 4'd9, 4'd11,
		4'd7, 4'd15, 4'd5, 4'd10, 4'd8, 4'd1, 4'd6, 4'd13, 4'd0, 4'd9, 4'd3, 4'd14, 4'd11, 4'd4, 4'd2, 4'd12,
		4'd5, 4'd13, 4'd15, 4'd6, 4'd9, 4'd2, 4'd12, 4'd10, 4'd11, 4'd7, 4'd8, 4'd1, 4'd4, 4'd3, 4'd14, 4'd0,
		4'd8, 4'd14, 4'd2, 4'd5, 4'd6, 4'd9, 4'd1, 4'd12, 4'd15, 4'd4, 4'd11, 4'd0, 4'd13, 4'd10, 4'd3, 4'd7,
		4'd1, 4'd7, 4'd14, 4'd13, 4'd0, 4'd5, 4'd8, 4'd3, 4'd4, 4'd15, 4'd10, 4'd6, 4'd9, 4'd12, 4'd11, 4'd2
	};

	typedef struct {
		cmd_t        command;
		logic [1:0]  key_select;
		logic [2:0]  word_index;
		logic [31:0] key_word;
		logic [63:0] data_block;
		logic        first_block;
	} request_t;

	logic clk;
	logic arst_n;

	tmagma_in_if  in_ch();
	tmagma_out_if out_ch();
	tmagma_cfg_if cfg_ch();

	triple_magma_cbc_cipher_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg_ch (cfg_ch)
	);

	request_t    pending_requests[$];
	logic [63:0] expected_blocks[$];
	request_t    in_flight;
	logic [63:0] wanted_block;

	logic [31:0] key_words [24];
	logic [63:0] chain_value;
	logic [63:0] iv_value;
	logic        decrypting;

	int idle_pct;
	int failures;
	int blocks_checked;
	int key_writes;
	int encrypt_blocks;
	int decrypt_blocks;
	int settings_used;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [31:0] mix_half(input logic [31:0] half, input logic [31:0] subkey);
		logic [31:0] sum;
		logic [31:0] sub;
		sum = half + subkey;
		for (int n = 0; n < 8; n++) begin
			sub[4*n +: 4] = SUBST[n][sum[4*n +: 4]];
		end
		return (sub << 11) | (sub >> 21);
	endfunction

	function automatic logic [63:0] magma_block(input logic [63:0] blk, input int key_no,
			input bit inverse);
		logic [31:0] hi;
		logic [31:0] lo;
		logic [31:0] nl;
		int sk;
		hi = blk[63:32];
		lo = blk[31:0];
		for (int r = 0; r < 32; r++) begin
			if (!inverse) begin
				sk = (r < 24) ? (r % 8) : (7 - r % 8);
			end else begin
				sk = (r < 8) ? (r % 8) : (7 - r % 8);
			end
			nl = mix_half(lo, key_words[key_no*8 + sk]) ^ hi;
			hi = lo;
			lo = nl;
		end
		return {lo, hi};
	endfunction

	function automatic void predict_request(input request_t r);
		logic [63:0] prev;
		logic [63:0] t;
		if (r.command == CMD_KEY) begin
			if (r.key_select != KEY_SEL_NONE) begin
				key_words[{r.key_select, r.word_index}] = r.key_word;
			end
			key_writes++;
			return;
		end
		prev = r.first_block ? iv_value : chain_value;
		if (!decrypting) begin
			t = magma_block(r.data_block ^ prev, 0, 1'b0);
			t = magma_block(t, 1, 1'b1);
			t = magma_block(t, 2, 1'b0);
			chain_value = t;
			expected_blocks.insert(expected_blocks.size(), t);
			encrypt_blocks++;
		end else begin
			t = magma_block(r.data_block, 2, 1'b1);
			t = magma_block(t, 1, 1'b0);
			t = magma_block(t, 0, 1'b1);
			chain_value = r.data_block;
			expected_blocks.insert(expected_blocks.size(), t ^ prev);
			decrypt_blocks++;
		end
	endfunction

	function automatic logic [31:0] random_word();
		int pick;
		pick = $urandom_range(19);
		if (pick == 0) begin
			return '0;
		end else if (pick == 1) begin
			return '1;
		end
		return $urandom;
	endfunction

	function automatic logic [63:0] random_block();
		int pick;
		pick = $urandom_range(19);
		if (pick == 0) begin
			return '0;
		end else if (pick == 1) begin
			return '1;
		end
		return {$urandom, $urandom};
	endfunction

	task automatic queue_key(input logic [1:0] ks, input logic [2:0] wi, input logic [31:0] w);
		request_t r;
		r.command     = CMD_KEY;
		r.key_select  = ks;
		r.word_index  = wi;
		r.key_word    = w;
		r.data_block  = {$urandom, $urandom};
		r.first_block = 1'($urandom_range(1));
		pending_requests.insert(pending_requests.size(), r);
	endtask

	task automatic queue_block(input logic [63:0] d, input logic first);
		request_t r;
		r.command     = CMD_BLOCK;
		r.key_select  = 2'($urandom_range(3));
		r.word_index  = 3'($urandom_range(7));
		r.key_word    = $urandom;
		r.data_block  = d;
		r.first_block = first;
		pending_requests.insert(pending_requests.size(), r);
	endtask

	// Mostly key loads and well-formed messages, with stray writes and
	// blocks that break the chain mixed in.
	task automatic queue_phase(input int budget);
		int left;
		int pick;
		int len;
		logic [1:0] ks;
		left = budget;
		while (left > 0) begin
			pick = $urandom_range(99);
			if (pick < 15) begin
				ks = 2'($urandom_range(2));
				for (int w = 0; w < 8; w++) begin
					queue_key(ks, 3'(w), random_word());
				end
				left -= 8;
			end else if (pick < 20) begin
				ks = 2'($urandom_range(3));
				queue_key(ks, 3'($urandom_range(7)), random_word());
				if (ks != KEY_SEL_NONE) begin
					left--;
				end
			end else if (pick < 25) begin
				queue_block(random_block(), 1'($urandom_range(1)));
				left--;
			end else begin
				len = $urandom_range(1, 8);
				queue_block(random_block(), 1'b1);
				for (int i = 1; i < len; i++) begin
					queue_block(random_block(), 1'b0);
				end
				left -= len;
			end
		end
	endtask

	task automatic write_register(input cfg_idx_t idx, input logic [63:0] value);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		if (idx == CFG_INIT_VECTOR) begin
			iv_value = value;
		end else begin
			decrypting = value[0];
		end
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (pending_requests.size() != 0 || in_ch.valid || expected_blocks.size() != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
		end else if (!in_ch.valid || in_ch.ready) begin
			if (in_ch.valid) begin
				predict_request(in_flight);
			end
			if (pending_requests.size() != 0 && $urandom_range(99) >= idle_pct) begin
				in_flight = pending_requests.pop_front();
				in_ch.command     <= in_flight.command;
				in_ch.key_select  <= in_flight.key_select;
				in_ch.word_index  <= in_flight.word_index;
				in_ch.key_word    <= in_flight.key_word;
				in_ch.data_block  <= in_flight.data_block;
				in_ch.first_block <= in_flight.first_block;
				in_ch.valid       <= 1'b1;
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_blocks.size() == 0) begin
					$error("result_block: expected none, actual %h", out_ch.result_block);
					failures++;
				end else begin
					wanted_block = expected_blocks.pop_front();
					blocks_checked++;
					if (out_ch.result_block !== wanted_block) begin
						$error("result_block: expected %h, actual %h", wanted_block,
							out_ch.result_block);
						failures++;
					end
				end
			end
			out_ch.ready <= ($urandom_range(99) >= idle_pct);
		end
	end

	initial begin
		#8ms;
		$display("triple_magma_cbc_cipher_top_tb NOT OK");
		$finish;
	end

	initial begin
		arst_n            = 1'b0;
		in_ch.valid       = 1'b0;
		in_ch.command     = CMD_KEY;
		in_ch.key_select  = '0;
		in_ch.word_index  = '0;
		in_ch.key_word    = '0;
		in_ch.data_block  = '0;
		in_ch.first_block = 1'b0;
		out_ch.ready      = 1'b0;
		cfg_ch.valid      = 1'b0;
		cfg_ch.index      = CFG_INIT_VECTOR;
		cfg_ch.data       = '0;
		idle_pct          = 35;
		failures          = 0;
		blocks_checked    = 0;
		key_writes        = 0;
		encrypt_blocks    = 0;
		decrypt_blocks    = 0;
		settings_used     = 1;
		chain_value       = '0;
		iv_value          = '0;
		decrypting        = 1'b0;
		for (int i = 0; i < 24; i++) begin
			key_words[i] = '0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Reset keys, chaining from the reset value, and an ignored key select.
		queue_block('0, 1'b0);
		queue_block('1, 1'b0);
		queue_key(KEY_SEL_NONE, 3'd7, '1);
		queue_block(64'h0123456789abcdef, 1'b1);
		queue_key(2'd0, 3'd0, '1);
		queue_key(2'd2, 3'd7, '0);
		queue_key(2'd1, 3'd3, $urandom);
		queue_block('1, 1'b1);
		queue_block('0, 1'b0);
		wait_drained();

		write_register(CFG_INIT_VECTOR, '1);
		write_register(CFG_DECRYPT_MODE, 64'd1);
		settings_used++;
		queue_block('0, 1'b1);
		queue_block('1, 1'b0);
		queue_key(2'd1, 3'd4, 32'h8000_0001);
		queue_block(64'h8000_0000_0000_0001, 1'b1);
		queue_block(random_block(), 1'b0);
		wait_drained();

		for (int phase = 0; phase < PHASES; phase++) begin
			idle_pct = (phase == 4) ? 0 : 35;
			case (phase % 3)
				0: write_register(CFG_INIT_VECTOR, '0);
				1: write_register(CFG_INIT_VECTOR, '1);
				default: write_register(CFG_INIT_VECTOR, {$urandom, $urandom});
			endcase
			write_register(CFG_DECRYPT_MODE, (phase % 2 == 0) ? 64'd0 : 64'd1);
			settings_used++;
			queue_phase(PHASE_ITEMS);
			wait_drained();
		end

		$display("Checked %0d result blocks (%0d encrypt, %0d decrypt) and %0d key writes",
			blocks_checked, encrypt_blocks, decrypt_blocks, key_writes);
		$display("across %0d register settings, with and without random idling.",
			settings_used);
		if (failures == 0 && expected_blocks.size() == 0) begin
			$display("triple_magma_cbc_cipher_top_tb OK");
		end else begin
			$display("triple_magma_cbc_cipher_top_tb NOT OK");
		end
		$finish;
	end

endmodule
